FILE: rtl/rbst_pkg.sv
package rbst_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned NUM_STAGES = 7;

  localparam word_t QNAN_DEFAULT = 32'hFFC0_0000;
  localparam word_t QNAN_BIT     = 32'h0040_0000;
  localparam word_t FP_ZERO      = 32'h0000_0000;
  localparam word_t MAX_DIST_RST = 32'h7F80_0000;

  localparam logic [7:0] EXP_MAX  = 8'hFF;
  localparam logic [2:0] REG_ADDR_MAX_DIST = 3'd0;

  function automatic logic f_nan(input word_t x);
    return (x[30:23] == EXP_MAX) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic f_inf(input word_t x);
    return (x[30:23] == EXP_MAX) && (x[22:0] == 23'd0);
  endfunction

  // ordered a < b, false on nan and on equal values including signed zeros
  function automatic logic f_lt(input word_t a, input word_t b);
    logic res;
    res = 1'b0;
    if (!f_nan(a) && !f_nan(b) && !((a[30:0] == 31'd0) && (b[30:0] == 31'd0))) begin
      if (a[31] != b[31]) begin
        res = a[31];
      end else if (!a[31]) begin
        res = a[30:0] < b[30:0];
      end else begin
        res = a[30:0] > b[30:0];
      end
    end
    return res;
  endfunction

  function automatic logic f_ge(input word_t a, input word_t b);
    return !f_nan(a) && !f_nan(b) && !f_lt(a, b);
  endfunction

endpackage

FILE: rtl/rbst_fsub.sv
// single precision a - b, round to nearest even, two register stages
module rbst_fsub
  import rbst_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  word_t a,
  input  word_t b,
  output word_t y
);

  // stage 1: order operands, align, add or subtract
  logic        sa, sb;
  logic [7:0]  ea, eb, eb_big, es, d;
  logic [23:0] ma, mb, m_big, m_sml;
  logic [26:0] m27s, shd, al;
  logic        st, a_big, s_big;
  logic [27:0] sum;
  logic        spc;
  word_t       spc_val;

  always_comb begin
    sa = a[31];
    sb = ~b[31];
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    a_big = a[30:0] >= b[30:0];
    eb_big = a_big ? ea : eb;
    es     = a_big ? eb : ea;
    m_big  = a_big ? ma : mb;
    m_sml  = a_big ? mb : ma;
    s_big  = a_big ? sa : sb;
    d = eb_big - es;
    m27s = {m_sml, 3'b000};
    shd = m27s >> d;
    st = |(m27s & ~(27'h7FF_FFFF << d));
    if (d > 8'd26) begin
      al = {26'd0, |m_sml};
    end else begin
      al = {shd[26:1], shd[0] | st};
    end
    if (sa == sb) begin
      sum = {1'b0, m_big, 3'b000} + {1'b0, al};
    end else begin
      sum = {1'b0, m_big, 3'b000} - {1'b0, al};
    end
    spc = 1'b1;
    if (f_nan(a)) begin
      spc_val = a | QNAN_BIT;
    end else if (f_nan(b)) begin
      spc_val = b | QNAN_BIT;
    end else if (f_inf(a) && f_inf(b)) begin
      spc_val = (sa == sb) ? a : QNAN_DEFAULT;
    end else if (f_inf(a)) begin
      spc_val = a;
    end else if (f_inf(b)) begin
      spc_val = {sb, b[30:0]};
    end else begin
      spc = 1'b0;
      spc_val = FP_ZERO;
    end
  end

  logic        r_spc, r_sign, r_zsign;
  word_t       r_spc_val;
  logic [7:0]  r_exp;
  logic [27:0] r_sum;

  always_ff @(posedge clk) begin
    if (en) begin
      r_spc     <= spc;
      r_spc_val <= spc_val;
      r_sign    <= s_big;
      r_zsign   <= (sa == sb) ? sa : 1'b0;
      r_exp     <= eb_big;
      r_sum     <= sum;
    end
  end

  // stage 2: normalize and round
  logic [4:0]  lz, sh;
  logic [26:0] n;
  logic [8:0]  e;
  logic [7:0]  ef;
  logic        up;
  word_t       res;

  always_comb begin
    lz = 5'd26;
    for (int i = 0; i < 27; i++) begin
      if (r_sum[i]) lz = 5'(26 - i);
    end
    if (r_sum[27]) begin
      sh = 5'd0;
      n = {r_sum[27:2], r_sum[1] | r_sum[0]};
      e = {1'b0, r_exp} + 9'd1;
    end else begin
      sh = ({3'b000, lz} < r_exp - 8'd1) ? lz : 5'(r_exp - 8'd1);
      n = r_sum[26:0] << sh;
      e = {1'b0, r_exp} - {4'd0, sh};
    end
    ef = n[26] ? e[7:0] : 8'd0;
    up = n[2] & (n[1] | n[0] | n[3]);
    if (r_spc) begin
      res = r_spc_val;
    end else if (r_sum == 28'd0) begin
      res = {r_zsign, 31'd0};
    end else if (e >= 9'd255) begin
      res = {r_sign, EXP_MAX, 23'd0};
    end else begin
      res = {r_sign, ef, n[25:3]} + {31'd0, up};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= res;
    end
  end

endmodule

FILE: rtl/rbst_fmul.sv
// single precision a * b, round to nearest even, two register stages
module rbst_fmul
  import rbst_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  word_t a,
  input  word_t b,
  output word_t y
);

  logic        sgn, spc, za, zb;
  word_t       spc_val;
  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;

  always_comb begin
    sgn = a[31] ^ b[31];
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    za = a[30:0] == 31'd0;
    zb = b[30:0] == 31'd0;
    spc = 1'b1;
    if (f_nan(a)) begin
      spc_val = a | QNAN_BIT;
    end else if (f_nan(b)) begin
      spc_val = b | QNAN_BIT;
    end else if ((f_inf(a) && zb) || (f_inf(b) && za)) begin
      spc_val = QNAN_DEFAULT;
    end else if (f_inf(a) || f_inf(b)) begin
      spc_val = {sgn, EXP_MAX, 23'd0};
    end else if (za || zb) begin
      spc_val = {sgn, 31'd0};
    end else begin
      spc = 1'b0;
      spc_val = FP_ZERO;
    end
  end

  // stage 1: mantissa product and biased exponent
  logic              r_spc, r_sgn;
  word_t             r_spc_val;
  logic [47:0]       r_p;
  logic signed [9:0] r_e;

  always_ff @(posedge clk) begin
    if (en) begin
      r_spc     <= spc;
      r_spc_val <= spc_val;
      r_sgn     <= sgn;
      r_p       <= ma * mb;
      r_e       <= $signed({2'b00, ea}) + $signed({2'b00, eb}) - 10'sd127;
    end
  end

  // stage 2: normalize, denormalize on underflow, round
  logic [5:0]        lz;
  logic signed [9:0] et, rs;
  logic [47:0]       q;
  logic              stk, up;
  logic [7:0]        ef;
  word_t             res;

  always_comb begin
    lz = 6'd47;
    for (int i = 0; i < 48; i++) begin
      if (r_p[i]) lz = 6'(47 - i);
    end
    et = r_e + 10'sd1 - $signed({4'd0, lz});
    rs = -r_e;
    stk = 1'b0;
    if (et >= 10'sd1) begin
      q = r_p << lz;
    end else if (r_e >= 10'sd0) begin
      q = r_p << r_e[5:0];
    end else if (rs > 10'sd49) begin
      q = 48'd0;
      stk = |r_p;
    end else begin
      q = r_p >> rs[5:0];
      stk = |(r_p & ~({48{1'b1}} << rs[5:0]));
    end
    ef = (et >= 10'sd1) ? et[7:0] : 8'd0;
    up = q[23] & ((|q[22:0]) | stk | q[24]);
    if (r_spc) begin
      res = r_spc_val;
    end else if (et >= 10'sd255) begin
      res = {r_sgn, EXP_MAX, 23'd0};
    end else begin
      res = {r_sgn, ef, q[46:24]} + {31'd0, up};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= res;
    end
  end

endmodule

FILE: rtl/rbst_reduce.sv
// per-axis ordering, near/far reduction and hit decision, three register stages
module rbst_reduce
  import rbst_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  word_t lo [NUM_AXES],
  input  word_t hi [NUM_AXES],
  input  word_t reach,
  output logic  hit,
  output word_t near_distance,
  output word_t far_distance
);

  word_t entry [NUM_AXES];
  word_t exitd [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        entry[i] <= f_lt(lo[i], hi[i]) ? lo[i] : hi[i];
        exitd[i] <= f_lt(hi[i], lo[i]) ? lo[i] : hi[i];
      end
    end
  end

  word_t ent12, ext12, near_v, far_v;

  always_comb begin
    ent12 = f_lt(entry[2], entry[1]) ? entry[1] : entry[2];
    ext12 = f_lt(exitd[1], exitd[2]) ? exitd[1] : exitd[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      near_v <= f_lt(ent12, entry[0]) ? entry[0] : ent12;
      far_v  <= f_lt(exitd[0], ext12) ? exitd[0] : ext12;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= f_ge(far_v, near_v) && f_ge(far_v, FP_ZERO)
             && (f_lt(near_v, FP_ZERO) || !f_lt(reach, near_v));
      near_distance <= near_v;
      far_distance  <= far_v;
    end
  end

endmodule

FILE: rtl/ray_box_slab_test.sv
// Ray versus axis-aligned box slab test in IEEE single precision. Each input
// item carries a ray (origin, reciprocal direction) and a box (lower and upper
// corner); each item gives exactly one result item with hit, near and far.
// The datapath is a seven-stage pipeline: two stages of subtract (corner minus
// origin), two of multiply by the reciprocal direction, one of per-axis
// min/max, one of near/far reduction and one that decides hit and holds the
// result. A new item is taken every cycle unless the output stalls. The whole
// pipeline advances together and halts only while a result is waiting at the
// output and m_tready is low, so nothing is lost or repeated under stall.
// max_distance (byte address 0, reset +infinity) is read by the last stage and
// should only be written while no item is in flight. Rounding is to nearest
// even with subnormals kept; the arithmetic quiets a nan and keeps its payload.
module ray_box_slab_test
  import rbst_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // input item
  input  logic         s_tvalid,
  output logic         s_tready,
  // origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  // (32 bits each, lowest first)
  input  logic [383:0] s_tdata,
  // result item
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit [0], near_distance [32:1], far_distance [64:33], zeros above
  output logic [71:0]  m_tdata,
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // global advance: all stages hold together, and only a held output register makes them hold
  logic                  en;
  logic [NUM_STAGES-1:0] vld;
  word_t                 max_distance;

  assign en       = !vld[NUM_STAGES-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NUM_STAGES-2:0], s_tvalid};
    end
  end

  // config register
  assign pready = 1'b1;
  assign prdata = (paddr == REG_ADDR_MAX_DIST) ? max_distance : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance <= MAX_DIST_RST;
    end else if (psel && penable && pwrite && paddr == REG_ADDR_MAX_DIST) begin
      max_distance <= pwdata;
    end
  end

  // field unpacking
  word_t origin  [NUM_AXES];
  word_t inv_dir [NUM_AXES];
  word_t box_min [NUM_AXES];
  word_t box_max [NUM_AXES];

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      origin[i]  = s_tdata[32*i +: 32];
      inv_dir[i] = s_tdata[32*(NUM_AXES+i) +: 32];
      box_min[i] = s_tdata[32*(2*NUM_AXES+i) +: 32];
      box_max[i] = s_tdata[32*(3*NUM_AXES+i) +: 32];
    end
  end

  // reciprocal direction waits out the subtract stages
  word_t inv_d1 [NUM_AXES];
  word_t inv_d2 [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en) begin
      inv_d1 <= inv_dir;
      inv_d2 <= inv_d1;
    end
  end

  word_t d_lo [NUM_AXES];
  word_t d_hi [NUM_AXES];
  word_t t_lo [NUM_AXES];
  word_t t_hi [NUM_AXES];

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
    rbst_fsub u_sub_lo (.clk, .en, .a(box_min[g]), .b(origin[g]), .y(d_lo[g]));
    rbst_fsub u_sub_hi (.clk, .en, .a(box_max[g]), .b(origin[g]), .y(d_hi[g]));
    rbst_fmul u_mul_lo (.clk, .en, .a(d_lo[g]), .b(inv_d2[g]), .y(t_lo[g]));
    rbst_fmul u_mul_hi (.clk, .en, .a(d_hi[g]), .b(inv_d2[g]), .y(t_hi[g]));
  end

  logic  hit;
  word_t near_distance, far_distance;

  rbst_reduce u_reduce (
    .clk,
    .en,
    .lo(t_lo),
    .hi(t_hi),
    .reach(max_distance),
    .hit,
    .near_distance,
    .far_distance
  );

  assign m_tdata = {7'd0, far_distance, near_distance, hit};

`ifndef SYNTH
  // a hit never exits behind the origin
  a_hit_far_ahead: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && hit |-> !far_distance[31] || far_distance[30:0] == 31'd0)
    else $error("hit with negative far distance");

  // a hit never carries a nan near distance
  a_hit_near_num: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && hit |-> !f_nan(near_distance))
    else $error("hit with nan near distance");

  // input side only stalls while a result is held at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output backpressure");

  // an item taken with an empty pipe shows up after the full latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && vld == '0 && m_tready |=> ##6 m_tvalid)
    else $error("item lost in pipeline");
`endif

endmodule

FILE: verif/ray_box_slab_test_checker.sv
`timescale 1ns / 100ps

module ray_box_slab_test_checker
  import rbst_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [383:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [71:0]  m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic  hit;
    word_t near_d;
    word_t far_d;
  } box_result_t;

  box_result_t result_q[$];
  word_t       reach;

  function automatic logic is_nan(word_t x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 0);
  endfunction

  function automatic logic is_inf(word_t x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 0);
  endfunction

  function automatic logic is_zero(word_t x);
    return x[30:0] == 0;
  endfunction

  function automatic logic [127:0] sig_of(word_t x);
    return (x[30:23] == 0) ? {105'd0, x[22:0]} : {104'd0, 1'b1, x[22:0]};
  endfunction

  function automatic int lsb_exp(word_t x);
    return (x[30:23] == 0) ? -149 : int'(x[30:23]) - 150;
  endfunction

  // value is sig * 2^w, round to nearest even into single precision
  function automatic word_t round_pack(logic s, logic [127:0] sig, int w);
    int p;
    int sh;
    int e;
    logic [127:0] q;
    logic g;
    logic st;
    p = 0;
    for (int i = 0; i < 128; i++) if (sig[i]) p = i;
    sh = p - 23;
    if (sh < -149 - w) sh = -149 - w;
    if (sh > 127) begin
      q = 0;
    end else if (sh > 0) begin
      q = sig >> sh;
      g = sig[sh-1];
      st = (sig << (129 - sh)) != 0;
      if (g && (st || q[0])) q = q + 1;
    end else begin
      q = sig << (-sh);
    end
    if (q[24]) begin
      q = q >> 1;
      sh++;
    end
    if (q[23]) begin
      e = w + sh + 150;
      if (e >= 255) return {s, 8'hFF, 23'd0};
      return {s, e[7:0], q[22:0]};
    end
    return {s, 8'd0, q[22:0]};
  endfunction

  // a - b, nan operands quieted with payload, first one wins
  function automatic word_t fsub(word_t a, word_t b);
    word_t bn;
    word_t t;
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] aa;
    logic [127:0] bb;
    logic [127:0] mag;
    logic sa;
    logic sb;
    logic sr;
    int wa;
    int wb;
    int dw;
    int w;
    int sft;
    if (is_nan(a)) return a | QNAN_BIT;
    if (is_nan(b)) return b | QNAN_BIT;
    bn = b ^ 32'h8000_0000;
    if (is_inf(a) && is_inf(bn) && (a[31] != bn[31])) return QNAN_DEFAULT;
    if (is_inf(a)) return a;
    if (is_inf(bn)) return bn;
    if (lsb_exp(a) < lsb_exp(bn)) begin
      t = a;
      a = bn;
      bn = t;
    end
    ma = sig_of(a);
    mb = sig_of(bn);
    wa = lsb_exp(a);
    wb = lsb_exp(bn);
    sa = a[31];
    sb = bn[31];
    dw = wa - wb;
    if (dw <= 100) begin
      aa = ma << dw;
      bb = mb;
      w = wb;
    end else begin
      aa = ma << 100;
      w = wa - 100;
      sft = dw - 100;
      if (sft >= 24) begin
        bb = {127'd0, mb != 0};
      end else begin
        bb = mb >> sft;
        if ((mb & ((128'd1 << sft) - 1)) != 0) bb[0] = 1'b1;
      end
    end
    if (sa == sb) begin
      mag = aa + bb;
      sr = sa;
    end else if (aa >= bb) begin
      mag = aa - bb;
      sr = sa;
    end else begin
      mag = bb - aa;
      sr = sb;
    end
    if (mag == 0) return {sa & sb, 31'd0};
    return round_pack(sr, mag, w);
  endfunction

  function automatic word_t fmul(word_t a, word_t b);
    logic s;
    if (is_nan(a)) return a | QNAN_BIT;
    if (is_nan(b)) return b | QNAN_BIT;
    s = a[31] ^ b[31];
    if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) return QNAN_DEFAULT;
    if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
    if (is_zero(a) || is_zero(b)) return {s, 31'd0};
    return round_pack(s, sig_of(a) * sig_of(b), lsb_exp(a) + lsb_exp(b));
  endfunction

  // ordered less-than, false on nan and between zeros
  function automatic logic flt(word_t a, word_t b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if (is_zero(a) && is_zero(b)) return 1'b0;
    if (a[31] != b[31]) return a[31];
    if (!a[31]) return a[30:0] < b[30:0];
    return a[30:0] > b[30:0];
  endfunction

  function automatic logic fge(word_t a, word_t b);
    return !is_nan(a) && !is_nan(b) && !flt(a, b);
  endfunction

  function automatic box_result_t slab_test(logic [383:0] d, word_t lim);
    box_result_t r;
    word_t lo;
    word_t hi;
    word_t entry [3];
    word_t leave [3];
    word_t o;
    word_t inv;
    logic in_reach;
    for (int ax = 0; ax < 3; ax++) begin
      o = d[32*ax +: 32];
      inv = d[32*(3+ax) +: 32];
      lo = fmul(fsub(d[32*(6+ax) +: 32], o), inv);
      hi = fmul(fsub(d[32*(9+ax) +: 32], o), inv);
      entry[ax] = flt(lo, hi) ? lo : hi;
      leave[ax] = flt(hi, lo) ? lo : hi;
    end
    // selection keeps the axis 2 or running value whenever the compare fails
    r.near_d = flt(entry[2], entry[1]) ? entry[1] : entry[2];
    r.near_d = flt(r.near_d, entry[0]) ? entry[0] : r.near_d;
    r.far_d = flt(leave[1], leave[2]) ? leave[1] : leave[2];
    r.far_d = flt(leave[0], r.far_d) ? leave[0] : r.far_d;
    in_reach = flt(r.near_d, FP_ZERO) || !flt(lim, r.near_d);
    r.hit = fge(r.far_d, r.near_d) && fge(r.far_d, FP_ZERO) && in_reach;
    return r;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", field, got, want);
    fail_count++;
  endtask

  assign pending = result_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    box_result_t want;
    box_result_t got;
    if (rst) begin
      reach <= MAX_DIST_RST;
      result_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_ADDR_MAX_DIST) reach <= pwdata;
      if (s_tvalid && s_tready) result_q.push_back(slab_test(s_tdata, reach));
      if (m_tvalid && m_tready) begin
        got = box_result_t'({m_tdata[0], m_tdata[32:1], m_tdata[64:33]});
        if (result_q.size() == 0) begin
          report("unexpected item", m_tdata[31:0], 32'd0);
        end else begin
          want = result_q.pop_front();
          if (got.hit != want.hit) report("hit", {31'd0, got.hit}, {31'd0, want.hit});
          if (got.near_d != want.near_d) report("near", got.near_d, want.near_d);
          if (got.far_d != want.far_d) report("far", got.far_d, want.far_d);
        end
      end
    end
  end

endmodule

FILE: verif/ray_box_slab_test_tb.sv
`timescale 1ns / 100ps

module ray_box_slab_test_tb;
  import rbst_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 230;

  // handy single precision patterns
  localparam word_t F_ONE    = 32'h3F80_0000;
  localparam word_t F_TWO    = 32'h4000_0000;
  localparam word_t F_NONE   = 32'hBF80_0000;
  localparam word_t F_NTWO   = 32'hC000_0000;
  localparam word_t F_INF    = 32'h7F80_0000;
  localparam word_t F_NINF   = 32'hFF80_0000;
  localparam word_t F_QNAN   = 32'h7FC0_0001;
  localparam word_t F_SNAN   = 32'h7F80_0005;
  localparam word_t F_MINSUB = 32'h0000_0001;
  localparam word_t F_MAXF   = 32'h7F7F_FFFF;
  localparam word_t F_NMAXF  = 32'hFF7F_FFFF;
  localparam word_t F_NZERO  = 32'h8000_0000;
  localparam word_t F_TEN    = 32'h4120_0000;
  localparam word_t F_HUND   = 32'h42C8_0000;
  localparam word_t F_TINY   = 32'h0080_0000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // origin xyz, inv_dir xyz, box_min xyz, box_max xyz (32 bits each, lowest first)
  logic [383:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // hit [0], near_distance [32:1], far_distance [64:33]
  logic [71:0]  m_tdata;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  int  fail_count;
  int  pending;
  int  idle_cycles = 0;
  bit  no_idle = 1'b0;

  always #5 clk = ~clk;

  ray_box_slab_test u_dut (.*);

  ray_box_slab_test_checker u_checker (.*);

  // sink side stalls at random unless a quiet stretch is on
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= no_idle || ($urandom_range(99) >= 12);
  end

  // watchdog on cycles where neither side moves an item
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [383:0] ray_box(word_t ox, word_t oy, word_t oz,
                                           word_t ix, word_t iy, word_t iz,
                                           word_t lx, word_t ly, word_t lz,
                                           word_t hx, word_t hy, word_t hz);
    return {hz, hy, hx, lz, ly, lx, iz, iy, ix, oz, oy, ox};
  endfunction

  // mostly moderate floats so slabs overlap often, plus raw bits, specials, subnormals and extreme exponents
  function automatic word_t rand_float();
    word_t specials [10] = '{FP_ZERO, F_NZERO, F_INF, F_NINF, F_QNAN, F_SNAN,
                             F_MINSUB, F_MAXF, F_ONE, F_NONE};
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5:
        return {1'($urandom_range(1)), 8'($urandom_range(135, 120)), 23'($urandom)};
      6: return $urandom;
      7: return specials[$urandom_range(9)];
      8: return {1'($urandom_range(1)), 8'd0, 23'($urandom)};
      default:
        return {1'($urandom_range(1)), 8'($urandom_range(1) ? $urandom_range(254, 240)
                                                              : $urandom_range(10, 1)),
                23'($urandom)};
    endcase
  endfunction

  // mostly well-formed ray and box: moderate values, corners near the origin, now and then a rand_float field
  function automatic logic [383:0] rand_ray_box();
    logic [383:0] d;
    for (int i = 0; i < 12; i++) begin
      d[32*i +: 32] = ($urandom_range(9) == 0) ? rand_float()
                      : {1'($urandom_range(1)), 8'($urandom_range(130, 122)), 23'($urandom)};
    end
    return d;
  endfunction

  task automatic send(logic [383:0] d);
    if (!no_idle) begin
      while ($urandom_range(99) < 12) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (NUM_STAGES + 4) @(posedge clk);
  endtask

  task automatic write_reach(word_t v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_ADDR_MAX_DIST;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_phase(int n, bit pause_midway);
    for (int i = 0; i < n; i++) begin
      if (pause_midway && i == n / 2) drain();
      send(($urandom_range(9) < 7) ? rand_ray_box()
           : {rand_float(), rand_float(), rand_float(), rand_float(),
              rand_float(), rand_float(), rand_float(), rand_float(),
              rand_float(), rand_float(), rand_float(), rand_float()});
    end
  endtask

  initial begin
    word_t reaches [6] = '{FP_ZERO, 32'hFFFF_FFFF, F_TEN, F_MAXF, F_NZERO, F_ONE};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: plain hit, box behind, origin inside, swapped corners
    send(ray_box(FP_ZERO, FP_ZERO, FP_ZERO, F_ONE, F_ONE, F_ONE,
                 F_ONE, F_ONE, F_ONE, F_TWO, F_TWO, F_TWO));
    send(ray_box(FP_ZERO, FP_ZERO, FP_ZERO, F_ONE, F_ONE, F_ONE,
                 F_NTWO, F_NTWO, F_NTWO, F_NONE, F_NONE, F_NONE));
    send(ray_box(FP_ZERO, FP_ZERO, FP_ZERO, F_ONE, F_TWO, F_ONE,
                 F_NONE, F_NONE, F_NONE, F_ONE, F_ONE, F_ONE));
    send(ray_box(FP_ZERO, FP_ZERO, FP_ZERO, F_ONE, F_ONE, F_ONE,
                 F_TWO, F_TWO, F_TWO, F_ONE, F_ONE, F_ONE));
    // zero-width box and a negative direction
    send(ray_box(FP_ZERO, FP_ZERO, FP_ZERO, F_ONE, F_ONE, F_ONE,
                 F_ONE, F_ONE, F_ONE, F_ONE, F_ONE, F_ONE));
    send(ray_box(F_TEN, F_TEN, F_TEN, F_NONE, F_NONE, F_NONE,
                 F_ONE, F_ONE, F_ONE, F_TWO, F_TWO, F_TWO));
    // axis-parallel ray: infinite reciprocal, and zero times infinity
    send(ray_box(FP_ZERO, F_ONE, F_ONE, F_ONE, F_INF, F_NINF,
                 F_ONE, F_NONE, F_ONE, F_TWO, F_TWO, F_TWO));
    // nan origin, signaling nan direction, infinity minus infinity
    send(ray_box(F_QNAN, FP_ZERO, FP_ZERO, F_ONE, F_ONE, F_ONE,
                 F_ONE, F_ONE, F_ONE, F_TWO, F_TWO, F_TWO));
    send(ray_box(FP_ZERO, FP_ZERO, FP_ZERO, F_SNAN, F_ONE, F_ONE,
                 F_ONE, F_ONE, F_ONE, F_TWO, F_TWO, F_TWO));
    send(ray_box(F_INF, FP_ZERO, FP_ZERO, F_ONE, F_ONE, F_ONE,
                 F_INF, F_ONE, F_ONE, F_TWO, F_TWO, F_TWO));
    // subnormals, overflow to infinity, underflow to zero
    send(ray_box(FP_ZERO, FP_ZERO, FP_ZERO, F_MAXF, F_MAXF, F_ONE,
                 F_MINSUB, F_MINSUB, F_MINSUB, F_TINY, F_TINY, F_TINY));
    send(ray_box(F_NMAXF, F_NMAXF, F_NMAXF, F_ONE, F_ONE, F_ONE,
                 F_MAXF, F_MAXF, F_MAXF, F_MAXF, F_MAXF, F_MAXF));
    send(ray_box(FP_ZERO, FP_ZERO, FP_ZERO, F_TINY, F_TINY, F_TINY,
                 F_TINY, F_TINY, F_TINY, F_MINSUB, F_MINSUB, F_MINSUB));
    // signed zeros, all zeros, all ones
    send(ray_box(F_NZERO, F_NZERO, F_NZERO, F_NZERO, F_ONE, F_NZERO,
                 FP_ZERO, F_NZERO, FP_ZERO, F_NZERO, FP_ZERO, F_NZERO));
    send('0);
    send('1);
    // far box within the reset reach, and a box far behind the origin
    send(ray_box(FP_ZERO, FP_ZERO, FP_ZERO, F_ONE, F_ONE, F_ONE,
                 F_HUND, F_HUND, F_HUND, F_MAXF, F_MAXF, F_MAXF));
    send(ray_box(F_MAXF, F_MAXF, F_MAXF, F_MAXF, F_MAXF, F_MAXF,
                 F_NMAXF, F_NMAXF, F_NMAXF, F_NMAXF, F_NMAXF, F_NMAXF));

    random_phase(ITEMS_PER_PHASE, 1'b0);
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reach(reaches[ph]);
      no_idle = (ph == 1);
      send(ray_box(FP_ZERO, FP_ZERO, FP_ZERO, F_ONE, F_ONE, F_ONE,
                   F_TWO, F_TWO, F_TWO, F_HUND, F_HUND, F_HUND));
      random_phase(ITEMS_PER_PHASE - 30, ph == 2);
    end
    no_idle = 1'b0;

    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
